// ----- src/trcs_pkg.sv -----
`default_nettype none
package trcs_pkg;

   // Longest row handled; columns run from 1 to MAX_LINE.
   localparam int MAX_LINE = 4096;
   localparam int POS_W    = $clog2(MAX_LINE);
   localparam int COL_W    = POS_W + 1;
   localparam int CHAR_W   = 21;
   localparam int KIND_W   = 3;

   // An input item causes at most this many result items.
   localparam int MAX_RES  = 3;
   localparam int NRES_W   = 2;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;

   localparam int REQ_DATA_W = ((CHAR_W + 7) / 8) * 8;
   localparam int RSP_PAY_W  = COL_W + CHAR_W + POS_W;
   localparam int RSP_DATA_W = ((RSP_PAY_W + 7) / 8) * 8;

   localparam logic [CHAR_W-1:0] CH_PIPE   = CHAR_W'(32'h7C);
   localparam logic [CHAR_W-1:0] CH_BSLASH = CHAR_W'(32'h5C);
   localparam logic [CHAR_W-1:0] CH_N      = CHAR_W'(32'h6E);
   localparam logic [CHAR_W-1:0] CH_NL     = CHAR_W'(32'h0A);
   localparam logic [CHAR_W-1:0] CH_SPACE  = CHAR_W'(32'h20);

   localparam logic [KIND_W-1:0] K_START  = 3'd0;
   localparam logic [KIND_W-1:0] K_TEXT   = 3'd1;
   localparam logic [KIND_W-1:0] K_SPACES = 3'd2;
   localparam logic [KIND_W-1:0] K_END    = 3'd3;
   localparam logic [KIND_W-1:0] K_DROP   = 3'd4;
   localparam logic [KIND_W-1:0] K_DONE   = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [COL_W-1:0]  column;
      logic [CHAR_W-1:0] out_char;
      logic [POS_W-1:0]  run_length;
      logic              last_of_run;
   } trcs_res_type;

   // All result items caused by one input item, lowest index first.
   typedef struct packed {
      logic [NRES_W-1:0]               count;
      trcs_res_type [MAX_RES-1:0]      res;
   } trcs_batch_type;

endpackage
`default_nettype wire

// ----- src/trcs_core.sv -----
`default_nettype none
module trcs_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [trcs_pkg::CHAR_W-1:0]   char_code,
   input  wire logic                          char_valid,
   input  wire logic                          end_of_line,
   output trcs_pkg::trcs_batch_type           batch
);
   import trcs_pkg::*;

   logic             in_cell_ff, in_cell_in;
   logic             esc_ff, esc_in;
   logic             started_ff, started_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] spaces_ff, spaces_in;

   function automatic trcs_res_type mk(input logic [KIND_W-1:0] kind,
                                       input logic [COL_W-1:0] col,
                                       input logic [CHAR_W-1:0] ch,
                                       input logic [POS_W-1:0] run);
      trcs_res_type r;
      r.kind        = kind;
      r.column      = col;
      r.out_char    = ch;
      r.run_length  = run;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   always_comb begin
      trcs_res_type [MAX_RES-1:0] res;
      logic [NRES_W-1:0]          n;
      logic [COL_W-1:0]           col;
      logic [POS_W-1:0]           spaces_inc;

      res        = '0;
      n          = '0;
      col        = COL_W'(pos_ff) + COL_W'(1);
      spaces_inc = (spaces_ff == POS_W'(MAX_LINE - 1)) ? spaces_ff : spaces_ff + POS_W'(1);

      in_cell_in = in_cell_ff;
      esc_in     = esc_ff;
      started_in = started_ff;
      pos_in     = pos_ff;
      spaces_in  = spaces_ff;

      if (char_valid) begin
         if (pos_ff != POS_W'(MAX_LINE - 1)) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (!in_cell_ff) begin
            // Before the first pipe only escapes are tracked.
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (char_code == CH_BSLASH) begin
               esc_in = 1'b1;
            end else if (char_code == CH_PIPE) begin
               in_cell_in = 1'b1;
            end
         end else if (esc_ff) begin
            esc_in = 1'b0;
            if (end_of_line) begin
               res[n] = mk(K_DROP, '0, '0, '0);
               n = n + NRES_W'(1);
            end else if (char_code == CH_N) begin
               res[n] = mk(K_TEXT, '0, CH_NL, '0);
               n = n + NRES_W'(1);
            end else if (char_code == CH_PIPE || char_code == CH_BSLASH) begin
               res[n] = mk(K_TEXT, '0, char_code, '0);
               n = n + NRES_W'(1);
            end else if (char_code == CH_SPACE) begin
               // The backslash stays, the space is held like any other.
               res[n] = mk(K_TEXT, '0, CH_BSLASH, '0);
               n = n + NRES_W'(1);
               spaces_in = spaces_inc;
            end else begin
               res[n] = mk(K_TEXT, '0, CH_BSLASH, '0);
               n = n + NRES_W'(1);
               res[n] = mk(K_TEXT, '0, char_code, '0);
               n = n + NRES_W'(1);
            end
         end else if (char_code == CH_PIPE) begin
            if (!started_ff) begin
               res[n] = mk(K_START, col, '0, '0);
               n = n + NRES_W'(1);
            end
            res[n] = mk(K_END, '0, '0, '0);
            n = n + NRES_W'(1);
            started_in = 1'b0;
            spaces_in  = '0;
         end else if (char_code == CH_SPACE) begin
            if (started_ff) begin
               if (end_of_line) begin
                  res[n] = mk(K_DROP, '0, '0, '0);
                  n = n + NRES_W'(1);
               end else begin
                  spaces_in = spaces_inc;
               end
            end
         end else if (end_of_line) begin
            res[n] = mk(K_DROP, '0, '0, '0);
            n = n + NRES_W'(1);
         end else begin
            if (!started_ff) begin
               res[n] = mk(K_START, col, '0, '0);
               n = n + NRES_W'(1);
               started_in = 1'b1;
            end else if (spaces_ff != '0) begin
               res[n] = mk(K_SPACES, '0, '0, spaces_ff);
               n = n + NRES_W'(1);
               spaces_in = '0;
            end
            if (char_code == CH_BSLASH) begin
               esc_in = 1'b1;
            end else begin
               res[n] = mk(K_TEXT, '0, char_code, '0);
               n = n + NRES_W'(1);
            end
         end
      end else if (end_of_line && in_cell_ff && (started_ff || esc_ff)) begin
         res[n] = mk(K_DROP, '0, '0, '0);
         n = n + NRES_W'(1);
      end

      if (end_of_line) begin
         res[n] = mk(K_DONE, '0, '0, '0);
         n = n + NRES_W'(1);
         in_cell_in = 1'b0;
         esc_in     = 1'b0;
         started_in = 1'b0;
         pos_in     = '0;
         spaces_in  = '0;
      end

      if (n != '0) begin
         res[n - NRES_W'(1)].last_of_run = 1'b1;
      end

      batch.count = n;
      batch.res   = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cell_ff <= 1'b0;
         esc_ff     <= 1'b0;
         started_ff <= 1'b0;
         pos_ff     <= '0;
         spaces_ff  <= '0;
      end else if (accept) begin
         in_cell_ff <= in_cell_in;
         esc_ff     <= esc_in;
         started_ff <= started_in;
         pos_ff     <= pos_in;
         spaces_ff  <= spaces_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/trcs_queue.sv -----
`default_nettype none
module trcs_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire trcs_pkg::trcs_batch_type batch,
   output logic                          room,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output trcs_pkg::trcs_res_type        out_res
);
   import trcs_pkg::*;

   trcs_res_type     mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] wr_n;
   logic             pop;

   assign wr_n      = push ? CNT_W'(batch.count) : '0;
   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_res   = mem[rd_ptr_ff];
   // Room for a full batch is decided from the stored count alone.
   assign room      = (cnt_ff <= CNT_W'(QUEUE_DEPTH - MAX_RES));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(wr_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + wr_n - CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (push && (NRES_W'(i) < batch.count)) begin
            mem[wr_ptr_ff + PTR_W'(i)] <= batch.res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/table_row_cell_splitter.sv -----
// The result items of an input item are written to the result queue when the item is taken and are
// offered from there behind any results still waiting. Throughput: one input item per cycle while
// each item causes at most one result item and the queue has room; results of an item causing two
// or three are absorbed by an eight-entry result queue that drains one item per cycle while rsp_tready is high.
// Reset: synchronous, active high; clears the row state and empties the result queue.
`default_nettype none
module table_row_cell_splitter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input item: one code point of the row.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [trcs_pkg::REQ_DATA_W-1:0]   req_tdata,  // [20:0] char_code, rest zero
   input  wire logic                              req_tuser,  // [0] char_valid
   input  wire logic                              req_tlast,  // end_of_line
   // Result item.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [trcs_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // [12:0] column, [33:13] out_char,
                                                              // [45:34] run_length, rest zero
   output logic [trcs_pkg::KIND_W-1:0]            rsp_tuser,  // [2:0] kind
   output logic                                   rsp_tlast   // last_of_run
);
   import trcs_pkg::*;

   logic           accept;
   trcs_batch_type batch;
   trcs_res_type   head;
   logic           room;

   // An item is taken whenever the queue can hold every result it may cause, so the input
   // side keeps moving while earlier results still wait on the output side.
   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;

   // The splitter decides all results of an item in one pass of combinational logic from the
   // input and the registered row state (cell phase, escape, start flag, column, held spaces).
   trcs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_tdata[CHAR_W-1:0]),
      .char_valid  (req_tuser),
      .end_of_line (req_tlast),
      .batch       (batch)
   );

   // Up to three results per item are written in one cycle and leave one per cycle while rsp_tready is high.
   trcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .batch     (batch),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (head)
   );

   assign rsp_tdata = RSP_DATA_W'({head.run_length, head.out_char, head.column});
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_run;

endmodule
`default_nettype wire

// ----- src/trcs_checker.sv -----
`default_nettype none
module trcs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [trcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire logic                              req_tuser,
   input wire logic                              req_tlast,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [trcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [trcs_pkg::KIND_W-1:0]       rsp_tuser,
   input wire logic                              rsp_tlast
);
   import trcs_pkg::*;

   // The queue is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A waiting result item holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A cell start always carries a nonzero column.
   a_start_col: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_START |-> rsp_tdata[COL_W-1:0] != '0)
      else $error("cell start without a column");

   // The end of a row is always the last result of its item.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_DONE |-> rsp_tlast)
      else $error("line done not marked last");

   // A space run is never empty.
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == K_SPACES |-> rsp_tdata[RSP_PAY_W-1:COL_W+CHAR_W] != '0)
      else $error("empty space run");

endmodule

bind table_row_cell_splitter trcs_checker u_trcs_checker (.*);
`default_nettype wire
